FILE: src/loss_and_gradient_unit_macros.svh
// Assertion macros shared by the loss and gradient unit modules.
`ifndef LOSS_AND_GRADIENT_UNIT_MACROS_SVH
`define LOSS_AND_GRADIENT_UNIT_MACROS_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define LGU_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// When ante holds at a clock edge, cons must hold at the next edge.
`define LGU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/lgu_pkg.sv
// Types, constants and the log2 table of the loss and gradient unit.
`default_nettype none
package lgu_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int LOG_TABLE_BITS = 8;
   localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;

   localparam int DATA_W   = 24;
   localparam int VALUE_W  = 48;
   localparam int SUM_W    = 64;
   localparam int COUNT_W  = 25;
   localparam int DIM_W    = 13;
   localparam int EPS_W    = 15;
   localparam int N_W      = 2 * DIM_W;
   localparam int M_W      = $clog2(FRAC_BITS);
   localparam int MAG_W    = M_W + 1 + FRAC_BITS;
   localparam int LN_W     = MAG_W + 1;
   localparam int MUL_A_W  = 26;
   localparam int MUL_B_W  = 33;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int S_W      = 48;
   localparam int DIV_W    = 64;
   localparam int DVSR_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int PADDR_W  = 4;
   localparam int PDATA_W  = 32;

   localparam logic [31:0] LN2_Q32 = 32'd2977044471;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      MODE_MSE, MODE_MSE_GRAD, MODE_BCE, MODE_BCE_GRAD
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE, REG_ROW_COUNT, REG_COL_COUNT, REG_CLAMP_EPSILON
   } reg_index_type;

   typedef enum logic [2:0] {
      MUL_DIMS, MUL_SQ, MUL_MAG_P, MUL_MAG_Q, MUL_T_LNP, MUL_U_LNQ, MUL_DD
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NPROD, ST_NSTORE, ST_SQ, ST_LNP, ST_LNQ, ST_CET, ST_CEQ,
      ST_CEQ_ST, ST_ACC, ST_DD, ST_DIV_LOAD, ST_DIV, ST_EMIT
   } state_type;

   typedef struct packed {
      mode_type               mode;
      logic [DIM_W-1:0]       row_count;
      logic [DIM_W-1:0]       col_count;
      logic [EPS_W-1:0]       clamp_epsilon;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic       ld_n;
      logic       ld_lnp;
      logic       ld_lnq;
      logic       ld_s;
      logic       add_s;
      logic       acc;
      logic       div_load;
      logic       div_step;
      logic       emit;
      mul_op_type mul_op;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     last;
      logic     div_done;
      logic     out_free;
   } dp_status_type;

   typedef logic [LOG_TABLE_SIZE-1:0][FRAC_BITS-1:0] log_tab_type;

   // log2(1 + k/2^LOG_TABLE_BITS) in FRAC_BITS bits, by repeated squaring in Q1.30.
   function automatic log_tab_type log_tab_build();
      log_tab_type          tab;
      logic [63:0]          y;
      logic [FRAC_BITS-1:0] r;
      for (int k = 0; k < LOG_TABLE_SIZE; k++) begin
         y = (64'd1 << 30) + (64'(k) << (30 - LOG_TABLE_BITS));
         r = '0;
         for (int i = 0; i < FRAC_BITS; i++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30)) begin
               y = y >> 1;
               r[0] = 1'b1;
            end
         end
         tab[k] = r;
      end
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = log_tab_build();

endpackage
`default_nettype wire

FILE: src/lgu_if.sv
// Request and response channel interfaces of the loss and gradient unit.
`default_nettype none
interface lgu_req_if import lgu_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] target;
   logic signed [DATA_W-1:0] prediction;
   logic                     last;
   modport source (output valid, target, prediction, last, input ready);
   modport sink (input valid, target, prediction, last, output ready);
endinterface

interface lgu_rsp_if import lgu_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      is_loss;
   logic                      saturated;
   logic                      status;
   modport source (output valid, value, is_loss, saturated, status, input ready);
   modport sink (input valid, value, is_loss, saturated, status, output ready);
endinterface
`default_nettype wire

FILE: src/lgu_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none
module lgu_csr import lgu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);
   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_MODE:          cfg_in.mode = mode_type'(pwdata[1:0]);
            REG_ROW_COUNT:     cfg_in.row_count = pwdata[DIM_W-1:0];
            REG_COL_COUNT:     cfg_in.col_count = pwdata[DIM_W-1:0];
            REG_CLAMP_EPSILON: cfg_in.clamp_epsilon = pwdata[EPS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_MODE:          prdata = PDATA_W'(cfg_ff.mode);
         REG_ROW_COUNT:     prdata = PDATA_W'(cfg_ff.row_count);
         REG_COL_COUNT:     prdata = PDATA_W'(cfg_ff.col_count);
         REG_CLAMP_EPSILON: prdata = PDATA_W'(cfg_ff.clamp_epsilon);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= MODE_MSE;
         cfg_ff.row_count     <= DIM_W'(1);
         cfg_ff.col_count     <= DIM_W'(1);
         cfg_ff.clamp_epsilon <= EPS_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

FILE: src/lgu_ctrl.sv
// Sequencer that steps the datapath through one transaction.
`default_nettype none
`include "loss_and_gradient_unit_macros.svh"
module lgu_ctrl import lgu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output cmd_type       cmd
);
   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mul_op = MUL_DIMS;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_NPROD;
            end
         end
         ST_NPROD: begin
            cmd.mul_op = MUL_DIMS;
            state_in   = ST_NSTORE;
         end
         ST_NSTORE: begin
            cmd.ld_n = 1'b1;
            case (status.mode)
               MODE_MSE:      state_in = ST_SQ;
               MODE_MSE_GRAD: state_in = ST_DIV_LOAD;
               MODE_BCE:      state_in = ST_LNP;
               MODE_BCE_GRAD: state_in = ST_DD;
               default:       state_in = ST_IDLE;
            endcase
         end
         ST_SQ: begin
            cmd.mul_op = MUL_SQ;
            state_in   = ST_ACC;
         end
         ST_LNP: begin
            cmd.mul_op = MUL_MAG_P;
            state_in   = ST_LNQ;
         end
         ST_LNQ: begin
            cmd.mul_op = MUL_MAG_Q;
            cmd.ld_lnp = 1'b1;
            state_in   = ST_CET;
         end
         ST_CET: begin
            cmd.mul_op = MUL_T_LNP;
            cmd.ld_lnq = 1'b1;
            state_in   = ST_CEQ;
         end
         ST_CEQ: begin
            cmd.mul_op = MUL_U_LNQ;
            cmd.ld_s   = 1'b1;
            state_in   = ST_CEQ_ST;
         end
         ST_CEQ_ST: begin
            cmd.add_s = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last ? ST_DIV_LOAD : ST_IDLE;
         end
         ST_DD: begin
            cmd.mul_op = MUL_DD;
            state_in   = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LGU_ASSERT_IMPL(a_emit_needs_room, clock, reset, cmd.emit, status.out_free, "emit into a full output register")
   `LGU_ASSERT_NEXT(a_capture_starts, clock, reset, cmd.capture, state_ff == ST_NPROD, "capture did not start the sequence")
   `LGU_ASSERT_NEXT(a_div_to_emit, clock, reset, (state_ff == ST_DIV) && status.div_done, state_ff == ST_EMIT, "division end did not lead to emit")
endmodule
`default_nettype wire

FILE: src/lgu_dp.sv
// Datapath: input capture, shared multiplier, log unit, accumulator, divider, output register.
`default_nettype none
`include "loss_and_gradient_unit_macros.svh"
module lgu_dp import lgu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  cmd_type                   cmd,
   output dp_status_type             status,
   input  logic signed [DATA_W-1:0]  req_target,
   input  logic signed [DATA_W-1:0]  req_prediction,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_is_loss,
   output logic                      rsp_saturated,
   output logic                      rsp_status
);
   localparam logic signed [DATA_W:0]  ONE_W   = $signed((DATA_W+1)'(1) << FRAC_BITS);
   localparam logic [FRAC_BITS-1:0]    HALF_W  = FRAC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [VALUE_W-1:0]      VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0]      VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [DIV_W-VALUE_W:0]  EXACT_HI = (DIV_W-VALUE_W+1)'(1);

   // Captured transaction and per-item registers.
   logic signed [DATA_W-1:0]  t_ff, t_in, p_ff, p_in;
   logic                      last_ff, last_in;
   logic [COUNT_W-1:0]        count_ff, count_in, snap_ff, snap_in;
   logic                      stat_ff, stat_in;
   logic [FRAC_BITS-1:0]      pc_ff, pc_in, q_ff, q_in;
   logic [N_W-1:0]            n_ff, n_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [LN_W-1:0]    lnp_ff, lnp_in, lnq_ff, lnq_in;
   logic signed [S_W-1:0]     s_ff, s_in;
   logic signed [SUM_W-1:0]   loss_ff, loss_in;
   // Divider.
   logic [DVSR_W-1:0]         rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [DIV_W-1:0]          quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]      dcnt_ff, dcnt_in;
   logic                      neg_ff, neg_in;
   // Output register.
   logic                      ovalid_ff, ovalid_in;
   logic [VALUE_W-1:0]        oval_ff, oval_in;
   logic                      oloss_ff, oloss_in, osat_ff, osat_in, ostat_ff, ostat_in;

   logic [DIM_W-1:0]          rows_eff, cols_eff;
   logic [FRAC_BITS-1:0]      eps_eff;
   logic signed [DATA_W:0]    p_ext, t_ext, eps_w, hi_w, pc_w, d_mse, u_val;
   logic signed [N_W-1:0]     g_val, dg_val;
   logic [FRAC_BITS-1:0]      ln_x, norm;
   logic [M_W-1:0]            lead;
   logic [LOG_TABLE_BITS-1:0] tab_idx;
   logic [MAG_W-1:0]          mag;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic [COUNT_W-1:0]        count_inc;
   logic signed [S_W-1:0]     s_abs;
   logic signed [SUM_W-1:0]   term;
   logic signed [SUM_W:0]     sum_wide;
   logic [DVSR_W:0]           rem_sh;
   logic                      ge;
   logic                      out_free, big, exact;
   logic [VALUE_W-1:0]        q48;

   assign rows_eff = (cfg.row_count == '0) ? DIM_W'(1) : cfg.row_count;
   assign cols_eff = (cfg.col_count == '0) ? DIM_W'(1) : cfg.col_count;
   always_comb begin
      if (cfg.clamp_epsilon == '0) begin
         eps_eff = FRAC_BITS'(1);
      end else if (FRAC_BITS'(cfg.clamp_epsilon) > HALF_W) begin
         eps_eff = HALF_W;
      end else begin
         eps_eff = FRAC_BITS'(cfg.clamp_epsilon);
      end
   end

   // Clamp of the prediction to [eps, 1-eps].
   assign p_ext = (DATA_W+1)'(p_ff);
   assign t_ext = (DATA_W+1)'(t_ff);
   assign eps_w = $signed((DATA_W+1)'(eps_eff));
   assign hi_w  = ONE_W - eps_w;
   always_comb begin
      pc_w = (p_ext < eps_w) ? eps_w : p_ext;
      if (pc_w > hi_w) begin
         pc_w = hi_w;
      end
   end

   assign d_mse  = t_ext - p_ext;
   assign u_val  = ONE_W - t_ext;
   assign g_val  = $signed({p_ext - t_ext, 1'b0});
   assign dg_val = $signed(N_W'(pc_ff)) - N_W'(t_ff);

   // Log2 magnitude: leading one, table lookup on the bits below it.
   assign ln_x = (cmd.mul_op == MUL_MAG_Q) ? q_ff : pc_ff;
   always_comb begin
      lead = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (ln_x[i]) begin
            lead = M_W'(i);
         end
      end
   end
   assign norm    = ln_x << (M_W'(FRAC_BITS - 1) - lead);
   assign tab_idx = norm[FRAC_BITS-2 -: LOG_TABLE_BITS];
   assign mag     = MAG_W'({((M_W+1)'(FRAC_BITS) - {1'b0, lead}), {FRAC_BITS{1'b0}}})
                    - MAG_W'(LOG_TAB[tab_idx]);

   // Shared multiplier operand selection.
   always_comb begin
      case (cmd.mul_op)
         MUL_DIMS: begin
            mul_a = $signed(MUL_A_W'(rows_eff));
            mul_b = $signed(MUL_B_W'(cols_eff));
         end
         MUL_SQ: begin
            mul_a = MUL_A_W'(d_mse);
            mul_b = MUL_B_W'(d_mse);
         end
         MUL_MAG_P, MUL_MAG_Q: begin
            mul_a = $signed(MUL_A_W'(mag));
            mul_b = $signed(MUL_B_W'(LN2_Q32));
         end
         MUL_T_LNP: begin
            mul_a = MUL_A_W'(t_ff);
            mul_b = MUL_B_W'(lnp_ff);
         end
         MUL_U_LNQ: begin
            mul_a = MUL_A_W'(u_val);
            mul_b = MUL_B_W'(lnq_ff);
         end
         MUL_DD: begin
            mul_a = $signed(MUL_A_W'(pc_ff));
            mul_b = $signed(MUL_B_W'(q_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // Loss term of the current element.
   assign s_abs = s_ff[S_W-1] ? -s_ff : s_ff;
   always_comb begin
      if (cfg.mode == MODE_MSE) begin
         term = $signed(SUM_W'(prod_ff[PROD_W-1:FRAC_BITS]));
      end else if (s_ff[S_W-1]) begin
         term = SUM_W'(s_abs >>> FRAC_BITS);
      end else begin
         term = -SUM_W'(s_abs >>> FRAC_BITS);
      end
   end
   assign sum_wide = (SUM_W+1)'(loss_ff) + (SUM_W+1)'(term);

   assign count_inc = (count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
   assign rem_sh    = {rem_ff, quo_ff[DIV_W-1]};
   assign ge        = rem_sh >= {1'b0, dvsr_ff};
   assign out_free  = !ovalid_ff || rsp_ready;
   assign big       = |quo_ff[DIV_W-1:VALUE_W-1];
   assign exact     = (quo_ff[DIV_W-1:VALUE_W-1] == EXACT_HI) && (quo_ff[VALUE_W-2:0] == '0);
   assign q48       = quo_ff[VALUE_W-1:0];

   always_comb begin
      t_in = t_ff;   p_in = p_ff;   last_in = last_ff;
      count_in = count_ff;   snap_in = snap_ff;   stat_in = stat_ff;
      pc_in = pc_ff;   q_in = q_ff;   n_in = n_ff;
      lnp_in = lnp_ff;   lnq_in = lnq_ff;   s_in = s_ff;   loss_in = loss_ff;
      rem_in = rem_ff;   dvsr_in = dvsr_ff;   quo_in = quo_ff;
      dcnt_in = dcnt_ff;   neg_in = neg_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      oval_in = oval_ff;   oloss_in = oloss_ff;   osat_in = osat_ff;   ostat_in = ostat_ff;

      if (cmd.capture) begin
         t_in     = req_target;
         p_in     = req_prediction;
         last_in  = req_last;
         snap_in  = count_inc;
         count_in = req_last ? '0 : count_inc;
      end
      if (cmd.ld_n) begin
         n_in    = prod_ff[N_W-1:0];
         stat_in = last_ff && (N_W'(snap_ff) != prod_ff[N_W-1:0]);
         pc_in   = pc_w[FRAC_BITS-1:0];
         q_in    = FRAC_BITS'(ONE_W - pc_w);
      end
      if (cmd.ld_lnp) begin
         lnp_in = -$signed({1'b0, prod_ff[32 +: MAG_W]});
      end
      if (cmd.ld_lnq) begin
         lnq_in = -$signed({1'b0, prod_ff[32 +: MAG_W]});
      end
      if (cmd.ld_s) begin
         s_in = prod_ff[S_W-1:0];
      end
      if (cmd.add_s) begin
         s_in = s_ff + prod_ff[S_W-1:0];
      end
      if (cmd.acc) begin
         if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            loss_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            loss_in = sum_wide[SUM_W-1:0];
         end
      end
      if (cmd.div_load) begin
         rem_in  = '0;
         dcnt_in = '0;
         case (cfg.mode)
            MODE_MSE, MODE_BCE: begin
               neg_in  = loss_ff[SUM_W-1];
               quo_in  = loss_ff[SUM_W-1] ? DIV_W'(-loss_ff) : DIV_W'(loss_ff);
               dvsr_in = (cfg.mode == MODE_MSE) ? DVSR_W'(n_ff) : DVSR_W'(cols_eff);
               loss_in = '0;
            end
            MODE_MSE_GRAD: begin
               neg_in  = g_val[N_W-1];
               quo_in  = DIV_W'(g_val[N_W-1] ? N_W'(-g_val) : N_W'(g_val));
               dvsr_in = DVSR_W'(n_ff);
            end
            MODE_BCE_GRAD: begin
               neg_in  = dg_val[N_W-1];
               quo_in  = DIV_W'(dg_val[N_W-1] ? N_W'(-dg_val) : N_W'(dg_val)) << 32;
               dvsr_in = prod_ff[DVSR_W-1:0];
            end
            default: begin
               neg_in  = 1'b0;
               quo_in  = '0;
               dvsr_in = DVSR_W'(1);
            end
         endcase
      end
      if (cmd.div_step) begin
         rem_in  = ge ? DVSR_W'(rem_sh - {1'b0, dvsr_ff}) : rem_sh[DVSR_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], ge};
         dcnt_in = dcnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.emit) begin
         ovalid_in = 1'b1;
         oloss_in  = (cfg.mode == MODE_MSE) || (cfg.mode == MODE_BCE);
         ostat_in  = stat_ff;
         if (big) begin
            oval_in = neg_ff ? VAL_MIN : VAL_MAX;
         end else begin
            oval_in = neg_ff ? -q48 : q48;
         end
         // A negative quotient of exactly 2^47 fits, except that the gradient
         // of cross entropy flags it as clipped.
         osat_in = big && !(neg_ff && exact && (cfg.mode != MODE_BCE_GRAD));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         loss_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         loss_ff   <= loss_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;   p_ff <= p_in;   last_ff <= last_in;
      snap_ff <= snap_in;   stat_ff <= stat_in;
      pc_ff <= pc_in;   q_ff <= q_in;   n_ff <= n_in;   prod_ff <= prod_in;
      lnp_ff <= lnp_in;   lnq_ff <= lnq_in;   s_ff <= s_in;
      rem_ff <= rem_in;   dvsr_ff <= dvsr_in;   quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;   neg_ff <= neg_in;
      oval_ff <= oval_in;   oloss_ff <= oloss_in;   osat_ff <= osat_in;
      ostat_ff <= ostat_in;
   end

   assign status.mode     = cfg.mode;
   assign status.last     = last_ff;
   assign status.div_done = (dcnt_ff == {DIV_CNT_W{1'b1}});
   assign status.out_free = out_free;

   assign rsp_valid     = ovalid_ff;
   assign rsp_value     = $signed(oval_ff);
   assign rsp_is_loss   = oloss_ff;
   assign rsp_saturated = osat_ff;
   assign rsp_status    = ostat_ff;

   `LGU_ASSERT_IMPL(a_divisor_nonzero, clock, reset, cmd.div_step, dvsr_ff != '0, "divide step with a zero divisor")
endmodule
`default_nettype wire

FILE: src/loss_and_gradient_unit.sv
// Top level of the loss and gradient unit: registers, sequencer and datapath.
`default_nettype none
// The unit takes one matrix element (target, prediction, last) per request
// transaction, both in signed Q8.16, and works in one of four modes set by the
// mode register: mean squared error, its gradient, binary cross entropy, or its
// gradient. The loss modes accumulate silently and return one response
// transaction holding the loss on the element marked last; the gradient modes
// return one response per element. Elements are processed one at a time by a
// sequencer driving a datapath with one shared 26x33 multiplier and one
// restoring divider that retires one quotient bit per cycle. An element that
// only accumulates passes through the multiplier steps of its mode and the
// accumulator before the unit accepts the next one. Every response passes
// through the divider, so a gradient element or a final loss occupies the
// unit until the division ends and the output register is free.
// The finished result sits in an output register, so the unit accepts the
// next element while it waits, and only stalls again when a second result is
// ready before the first was taken. The configuration registers sit at byte
// addresses 0 (mode), 4 (row_count), 8 (col_count) and 12 (clamp_epsilon);
// write them only while no element is in flight. A row or column count of
// zero acts as one, and the response's status bit reports a mismatch between
// the elements seen and rows times columns on the last element.
module loss_and_gradient_unit import lgu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   lgu_req_if.sink            req_ch,
   lgu_rsp_if.source          rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);
   cfg_type       cfg;
   cmd_type       cmd;
   dp_status_type status;
   logic          req_ready;

   // Configuration registers.
   lgu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The sequencer accepts a request transaction only when it is back at rest.
   lgu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // The datapath owns the output register that drives the response channel.
   lgu_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_target     (req_ch.target),
      .req_prediction (req_ch.prediction),
      .req_last       (req_ch.last),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_value      (rsp_ch.value),
      .rsp_is_loss    (rsp_ch.is_loss),
      .rsp_saturated  (rsp_ch.saturated),
      .rsp_status     (rsp_ch.status)
   );
endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench of the loss and gradient unit: predictor, driver, monitor and stimulus.
`default_nettype none
module tb;
   import lgu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The unit is exercised through its request and response channels and its
   // APB-style register port. Every accepted request transaction is run
   // through a local fixed-point predictor of the four loss and gradient
   // modes. Any result it produces is queued and compared field by field with
   // the next response transaction. Registers are only rewritten while the
   // unit is idle.

   localparam longint ONE       = 64'sd65536;
   localparam longint SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MIN   = -SUM_MAX - 1;
   localparam longint OUT_MAX   = (64'sd1 <<< 47) - 1;
   localparam longint OUT_MIN   = -OUT_MAX - 1;
   localparam int     IDLE_WAIT = 100;
   localparam int     WATCHDOG  = 5000;
   localparam int     ITEM_GOAL = 1150;

   typedef struct {
      logic signed [DATA_W-1:0] tgt;
      logic signed [DATA_W-1:0] pred;
      logic                     last;
   } element_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      is_loss;
      logic                      saturated;
      logic                      status;
   } loss_result_type;

   logic               clock;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   lgu_req_if req_ch ();
   lgu_rsp_if rsp_ch ();

   loss_and_gradient_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the registers and of the unit's accumulator state.
   mode_type         cur_mode;
   logic [DIM_W-1:0] cur_rows;
   logic [DIM_W-1:0] cur_cols;
   logic [EPS_W-1:0] cur_eps;
   longint           loss_acc;
   int unsigned      elem_seen;
   logic [15:0]      log2_frac [LOG_TABLE_SIZE];

   element_type     pending_elems [$];
   loss_result_type expected_results [$];

   int  errors;
   int  items_queued;
   int  items_taken;
   int  results_seen;
   int  phases_run;
   int  idle_cycles;
   logic took;

   // log2(1 + k/256) in 16 fraction bits, by repeated squaring in Q1.30.
   task automatic build_log2_table();
      longint unsigned y;
      logic [15:0]     r;
      for (int k = 0; k < LOG_TABLE_SIZE; k++) begin
         y = (64'd1 << 30) + (64'(k) << (30 - LOG_TABLE_BITS));
         r = '0;
         for (int i = 0; i < FRAC_BITS; i++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30)) begin
               y = y >> 1;
               r[0] = 1'b1;
            end
         end
         log2_frac[k] = r;
      end
   endtask

   // Natural log of x in Q.16 for x in [1, 65535]; always zero or negative.
   function automatic longint natural_log(longint x);
      int              msb;
      longint unsigned idx;
      longint          l2;
      longint unsigned mag;
      msb = 0;
      for (int i = 0; i < 63; i++)
         if (x[i]) msb = i;
      if (msb >= LOG_TABLE_BITS) idx = x >> (msb - LOG_TABLE_BITS);
      else idx = x << (LOG_TABLE_BITS - msb);
      idx = idx & 64'hFF;
      l2 = longint'(msb - FRAC_BITS) * ONE + longint'(log2_frac[idx]);
      mag = -l2;
      return -longint'((mag * 64'd2977044471) >> 32);
   endfunction

   function automatic longint add_clamped(longint a, longint b);
      if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
      if (b < 0 && a < SUM_MIN - b) return SUM_MIN;
      return a + b;
   endfunction

   function automatic longint clip_value(longint v, inout logic sat);
      if (v > OUT_MAX) begin
         sat = 1'b1;
         return OUT_MAX;
      end
      if (v < OUT_MIN) begin
         sat = 1'b1;
         return OUT_MIN;
      end
      return v;
   endfunction

   // Advances the shadow state by one element; returns 1 when the element
   // produces a response, which is then placed in res.
   function automatic bit predict_loss(element_type e, output loss_result_type res);
      longint          t, p, rows, cols, n, eps, term, v, pc, d;
      longint unsigned dd, num, qa, rem, fr;
      logic            sat, stat;
      t = e.tgt;
      p = e.pred;
      rows = (cur_rows == 0) ? 1 : cur_rows;
      cols = (cur_cols == 0) ? 1 : cur_cols;
      n = rows * cols;
      eps = (cur_eps == 0) ? 1 : cur_eps;
      if (eps > ONE / 2) eps = ONE / 2;
      sat = 1'b0;
      stat = 1'b0;
      res = '{default: '0};
      if (elem_seen < 32'h1FF_FFFF) elem_seen++;
      if (e.last) begin
         stat = (longint'(elem_seen) != n);
         elem_seen = 0;
      end
      pc = (p < eps) ? eps : p;
      if (pc > ONE - eps) pc = ONE - eps;
      if (cur_mode == MODE_MSE || cur_mode == MODE_BCE) begin
         if (cur_mode == MODE_MSE) begin
            d = t - p;
            term = longint'(longint'(d * d) >>> FRAC_BITS);
         end else begin
            term = -(t * natural_log(pc) + (ONE - t) * natural_log(ONE - pc)) / ONE;
         end
         loss_acc = add_clamped(loss_acc, term);
         if (!e.last) return 0;
         v = loss_acc / ((cur_mode == MODE_MSE) ? n : cols);
         loss_acc = 0;
         res.is_loss = 1'b1;
      end else if (cur_mode == MODE_MSE_GRAD) begin
         v = (2 * (p - t)) / n;
      end else begin
         d = pc - t;
         dd = pc * (ONE - pc);
         num = longint'((d < 0) ? -d : d) << FRAC_BITS;
         qa = num / dd;
         rem = num % dd;
         if (qa >= (64'd1 << (47 - FRAC_BITS))) begin
            sat = 1'b1;
            v = (d < 0) ? OUT_MIN : OUT_MAX;
         end else begin
            fr = 0;
            for (int i = 0; i < FRAC_BITS; i++) begin
               rem = rem << 1;
               fr = fr << 1;
               if (rem >= dd) begin
                  rem = rem - dd;
                  fr[0] = 1'b1;
               end
            end
            v = longint'((qa << FRAC_BITS) | fr);
            if (d < 0) v = -v;
         end
      end
      v = clip_value(v, sat);
      res.value = v[VALUE_W-1:0];
      res.saturated = sat;
      res.status = stat;
      return 1;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Monitor: predicts on every request transaction and checks every
   // response transaction against the oldest pending prediction.
   always @(posedge clock) begin
      loss_result_type predicted;
      loss_result_type want;
      element_type     e;
      if (reset) begin
         took <= 1'b0;
         idle_cycles <= 0;
      end else begin
         took <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            e.tgt = req_ch.target;
            e.pred = req_ch.prediction;
            e.last = req_ch.last;
            items_taken++;
            if (predict_loss(e, predicted)) expected_results.push_back(predicted);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response, value", rsp_ch.value, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.value !== want.value)
                  report_mismatch("value", rsp_ch.value, want.value);
               if (rsp_ch.is_loss !== want.is_loss)
                  report_mismatch("is_loss", rsp_ch.is_loss, want.is_loss);
               if (rsp_ch.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_ch.saturated, want.saturated);
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", rsp_ch.status, want.status);
            end
         end
         // Register writes and idle waits count too, so the limit is generous.
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG) begin
            $display("watchdog expired with %0d responses outstanding",
                     expected_results.size());
            $display("loss_and_gradient_unit: mismatch");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Driver: presents queued elements in bursts separated by random gaps.
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      element_type e;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = $urandom_range(1, 20);
         gap_left = 0;
      end else if (!req_ch.valid || took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_elems.size() != 0) begin
            e = pending_elems.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.target <= e.tgt;
            req_ch.prediction <= e.pred;
            req_ch.last <= e.last;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls in random runs whose density changes now and then.
   int stall_left;
   int stall_pct;
   int stall_epoch;
   always @(negedge clock) begin
      if (stall_epoch == 0) begin
         stall_epoch = 400;
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 15;
            default: stall_pct = 50;
         endcase
      end
      stall_epoch--;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic add_elem(longint t, longint p, bit l);
      element_type e;
      e.tgt = t[DATA_W-1:0];
      e.pred = p[DATA_W-1:0];
      e.last = l;
      pending_elems.push_back(e);
      items_queued++;
   endtask

   // Waits until every element has been taken and every response returned,
   // then lets the unit finish any silent accumulation.
   task automatic wait_drained();
      while (pending_elems.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [PDATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_config(mode_type m, logic [DIM_W-1:0] r, logic [DIM_W-1:0] c,
                             logic [EPS_W-1:0] eps);
      wait_drained();
      csr_write(REG_MODE, 32'(m));
      csr_write(REG_ROW_COUNT, 32'(r));
      csr_write(REG_COL_COUNT, 32'(c));
      csr_write(REG_CLAMP_EPSILON, 32'(eps));
      cur_mode = m;
      cur_rows = r;
      cur_cols = c;
      cur_eps = eps;
      phases_run++;
   endtask

   function automatic longint pick_value();
      case ($urandom_range(0, 5))
         0, 1: return longint'($signed($urandom_range(0, 24'hFFFFFF) & 24'hFFFFFF))
                  - (($urandom_range(0, 24'hFFFFFF) & 24'h800000) != 0 ? 0 : 0);
         2: begin
            case ($urandom_range(0, 5))
               0: return -64'sd8388608;
               1: return 64'sd8388607;
               2: return 0;
               3: return ONE;
               4: return 1;
               default: return -1;
            endcase
         end
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      if ($urandom_range(0, 9) != 0) return DIM_W'($urandom_range(1, 4));
      case ($urandom_range(0, 3))
         0: return DIM_W'(0);
         1: return DIM_W'(4096);
         2: return DIM_W'(8191);
         default: return DIM_W'($urandom_range(0, 8191));
      endcase
   endfunction

   function automatic logic [EPS_W-1:0] pick_eps();
      case ($urandom_range(0, 5))
         0: return EPS_W'(0);
         1: return EPS_W'(32767);
         2: return EPS_W'(1);
         3: return EPS_W'($urandom_range(1, 64));
         default: return EPS_W'($urandom_range(0, 32767));
      endcase
   endfunction

   initial begin
      int       n, len, nmat;
      longint   rows_eff, cols_eff;
      mode_type m;
      build_log2_table();
      errors = 0;
      items_queued = 0;
      items_taken = 0;
      results_seen = 0;
      phases_run = 0;
      stall_left = 0;
      stall_epoch = 0;
      cur_mode = MODE_MSE;
      cur_rows = 1;
      cur_cols = 1;
      cur_eps = 1;
      loss_acc = 0;
      elem_seen = 0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.target = '0;
      req_ch.prediction = '0;
      req_ch.last = 1'b0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes in squared error, one element per matrix.
      set_config(MODE_MSE, 1, 1, 1);
      add_elem(64'sd8388607, -64'sd8388608, 1);
      add_elem(0, 0, 1);
      add_elem(-64'sd8388608, 64'sd8388607, 1);
      // Zero dimensions act as one; three elements then flag a count error.
      set_config(MODE_MSE_GRAD, 0, 0, 0);
      add_elem(64'sd8388607, -64'sd8388608, 0);
      add_elem(-64'sd8388608, 64'sd8388607, 0);
      add_elem(0, 1, 1);
      // Cross entropy with predictions outside [0, 1] hitting the clamp.
      set_config(MODE_BCE, 2, 3, 0);
      add_elem(ONE, 0, 0);
      add_elem(0, ONE, 0);
      add_elem(ONE, -1, 0);
      add_elem(64'sd8388607, 64'sd8388607, 0);
      add_elem(-64'sd8388608, ONE / 2, 0);
      add_elem(ONE / 2, ONE / 3, 1);
      // Gradient of cross entropy at the widest and the narrowest clamp.
      set_config(MODE_BCE_GRAD, 1, 2, 32767);
      add_elem(ONE, 0, 0);
      add_elem(-64'sd8388608, 64'sd8388607, 1);
      set_config(MODE_BCE_GRAD, 4096, 4096, 1);
      add_elem(64'sd8388607, 1, 0);
      add_elem(-64'sd8388608, 0, 1);
      // A mode change mid-matrix keeps the running sum and count.
      set_config(MODE_MSE, 8191, 8191, 100);
      add_elem(ONE, 0, 0);
      add_elem(-ONE, ONE, 0);
      set_config(MODE_BCE, 1, 3, 100);
      add_elem(ONE, ONE / 4, 1);

      // Random phases: mostly well-formed matrices, some with a wrong length
      // and some left open so that state carries into the next setting.
      while (items_queued < ITEM_GOAL) begin
         m = mode_type'($urandom_range(0, 3));
         set_config(m, pick_dim(), pick_dim(), pick_eps());
         rows_eff = (cur_rows == 0) ? 1 : cur_rows;
         cols_eff = (cur_cols == 0) ? 1 : cur_cols;
         nmat = $urandom_range(1, 4);
         for (int j = 0; j < nmat; j++) begin
            n = int'(rows_eff * cols_eff);
            len = (n > 16) ? $urandom_range(1, 8) : n;
            if ($urandom_range(0, 6) == 0) len = len + 1;
            else if ($urandom_range(0, 6) == 0 && len > 1) len = len - 1;
            for (int i = 0; i < len; i++)
               add_elem(pick_value(), pick_value(),
                        (i == len - 1) && !(j == nmat - 1 && $urandom_range(0, 9) == 0));
         end
      end

      wait_drained();
      repeat (2 * IDLE_WAIT) @(posedge clock);
      $display("Ran %0d register settings, %0d elements accepted, %0d responses checked.",
               phases_run, items_taken, results_seen);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("loss_and_gradient_unit: match");
      end else begin
         $display("%0d errors, %0d responses never arrived", errors, expected_results.size());
         $display("loss_and_gradient_unit: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/lgu_pkg.sv
src/lgu_if.sv
src/lgu_csr.sv
src/lgu_ctrl.sv
src/lgu_dp.sv
src/loss_and_gradient_unit.sv
sim/tb.sv
